// File: hdl/circular_bitmap_range_mark_core_macros.svh
// Assertion shorthands shared by the RTL.
`ifndef CIRCULAR_BITMAP_RANGE_MARK_CORE_MACROS_SVH
`define CIRCULAR_BITMAP_RANGE_MARK_CORE_MACROS_SVH

// Hold an invariant at every clock edge outside reset.
`define CBRM_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");

// Hold a consequence in the cycle after its trigger.
`define CBRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequence violated");

`endif

// File: hdl/cbrm_pkg.sv
`timescale 1ns / 1ps

package cbrm_pkg;

   localparam int MAX_SLOTS_DEFAULT = 65536;
   localparam int WORD_BITS_DEFAULT = 64;

   localparam int SLOT_W = 16;
   localparam int LEN_W  = 17;

   localparam logic [LEN_W-1:0] BUF_LEN_RESET = 17'd65536;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [SLOT_W-1:0] start_slot;
      logic [LEN_W-1:0]  run_length;
      logic              mark_value;
   } req_type;

   typedef struct packed {
      logic any_marked;
      logic range_error;
   } rsp_type;

   typedef enum logic [3:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_CHECK,
      STATE_SPLIT,
      STATE_FIRST_RUN,
      STATE_FIRST_DRAIN,
      STATE_SECOND_RUN,
      STATE_SECOND_DRAIN,
      STATE_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic check;
      logic split;
      logic issue;
      logic load_second;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic run_error;
      logic run_empty;
      logic run_wraps;
      logic last_step;
      logic rsp_free;
   } ctl_status_type;

endpackage

// File: hdl/cbrm_ram.sv
`timescale 1ns / 1ps

module cbrm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             write_enable,
   input  logic [AW-1:0]    write_addr,
   input  logic [WIDTH-1:0] write_data,
   input  logic [AW-1:0]    read_addr,
   output logic [WIDTH-1:0] read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: hdl/cbrm_ctrl.sv
`timescale 1ns / 1ps
`include "circular_bitmap_range_mark_core_macros.svh"

module cbrm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cbrm_pkg::ctl_status_type status,
   output cbrm_pkg::ctl_cmd_type    cmd
);

   import cbrm_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         STATE_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = STATE_CHECK;
            end
         end
         STATE_CHECK: begin
            cmd.check = 1'b1;
            if (status.run_error || status.run_empty) begin
               state_in = STATE_FINISH;
            end else begin
               state_in = STATE_SPLIT;
            end
         end
         STATE_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = STATE_FIRST_RUN;
         end
         STATE_FIRST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_step) begin
               state_in = STATE_FIRST_DRAIN;
            end
         end
         STATE_FIRST_DRAIN: begin
            if (status.run_wraps) begin
               cmd.load_second = 1'b1;
               state_in        = STATE_SECOND_RUN;
            end else begin
               state_in = STATE_FINISH;
            end
         end
         STATE_SECOND_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_step) begin
               state_in = STATE_SECOND_DRAIN;
            end
         end
         STATE_SECOND_DRAIN: begin
            state_in = STATE_FINISH;
         end
         STATE_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   `CBRM_ASSERT_ALWAYS(a_cmd_exclusive, clock, reset, $onehot0({cmd.clear_step, cmd.accept, cmd.check, cmd.split, cmd.issue, cmd.load_second, cmd.load_rsp}))
   `CBRM_ASSERT_NEXT(a_reject_finishes, clock, reset, (state_ff == STATE_CHECK) && (status.run_error || status.run_empty), state_ff == STATE_FINISH)
   `CBRM_ASSERT_NEXT(a_last_drains, clock, reset, ((state_ff == STATE_FIRST_RUN) || (state_ff == STATE_SECOND_RUN)) && status.last_step, (state_ff == STATE_FIRST_DRAIN) || (state_ff == STATE_SECOND_DRAIN))

endmodule

// File: hdl/cbrm_datapath.sv
`timescale 1ns / 1ps

module cbrm_datapath #(
   parameter int MAX_SLOTS = cbrm_pkg::MAX_SLOTS_DEFAULT,
   parameter int WORD_BITS = cbrm_pkg::WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cbrm_pkg::ctl_cmd_type         cmd,
   output cbrm_pkg::ctl_status_type      status,
   input  cbrm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cbrm_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [cbrm_pkg::LEN_W-1:0]    csr_write_data
);

   import cbrm_pkg::*;

   localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BW        = $clog2(WORD_BITS);
   localparam int SHIFT_K   = 24;
   localparam int RECIP     = ((2 ** SHIFT_K) + WORD_BITS - 1) / WORD_BITS;
   localparam int RW        = $clog2(RECIP + 1);
   localparam int PW        = SLOT_W + RW;
   localparam logic [LEN_W-1:0] MAX_LEN =
      (MAX_SLOTS < (2 ** LEN_W)) ? LEN_W'(MAX_SLOTS) : '1;
   localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

   logic [LEN_W-1:0]     buf_len_ff, buf_len_in;
   logic [AW-1:0]        clear_addr_ff, clear_addr_in;
   logic                 op_ff, op_in;
   logic                 mark_ff, mark_in;
   logic [SLOT_W-1:0]    start_ff, start_in;
   logic [LEN_W-1:0]     count_ff, count_in;
   logic [SLOT_W-1:0]    quot_ff, quot_in;
   logic [LEN_W-1:0]     cnt1_ff, cnt1_in;
   logic [LEN_W-1:0]     cnt2_ff, cnt2_in;
   logic                 wrap_ff, wrap_in;
   logic [AW-1:0]        word_ff, word_in;
   logic [BW-1:0]        bit_ff, bit_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic                 apply_valid_ff, apply_valid_in;
   logic [WORD_BITS-1:0] apply_mask_ff, apply_mask_in;
   logic [AW-1:0]        apply_word_ff, apply_word_in;
   logic                 hit_ff, hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [LEN_W-1:0]     len_eff;
   logic [LEN_W-1:0]     start_ext;
   logic [LEN_W-1:0]     avail;
   logic                 run_error;
   logic [PW-1:0]        product;
   logic [LEN_W-1:0]     space;
   logic                 last_step;
   logic [LEN_W-1:0]     step_n;
   logic [WORD_BITS-1:0] step_mask;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [WORD_BITS-1:0] ram_rdata;

   assign len_eff   = (buf_len_ff > MAX_LEN) ? MAX_LEN : buf_len_ff;
   assign start_ext = LEN_W'(start_ff);
   assign avail     = len_eff - start_ext;
   assign run_error = (start_ext >= len_eff) || (count_ff > len_eff);
   assign product   = PW'(start_ff) * PW'(RECIP);

   assign space     = LEN_W'(WORD_BITS) - LEN_W'(bit_ff);
   assign last_step = (rem_ff <= space);
   assign step_n    = last_step ? rem_ff : space;
   assign step_mask = ({WORD_BITS{1'b1}} >> (LEN_W'(WORD_BITS) - step_n)) << bit_ff;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = apply_word_ff;
      ram_wdata = mark_ff ? (ram_rdata | apply_mask_ff) : (ram_rdata & ~apply_mask_ff);
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = clear_addr_ff;
         ram_wdata = '0;
      end else if (apply_valid_ff && (op_ff == OP_WRITE)) begin
         ram_we = 1'b1;
      end
   end

   cbrm_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_mark_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_addr   (ram_waddr),
      .write_data   (ram_wdata),
      .read_addr    (word_ff),
      .read_data    (ram_rdata)
   );

   always_comb begin
      buf_len_in     = buf_len_ff;
      clear_addr_in  = clear_addr_ff;
      op_in          = op_ff;
      mark_in        = mark_ff;
      start_in       = start_ff;
      count_in       = count_ff;
      quot_in        = quot_ff;
      cnt1_in        = cnt1_ff;
      cnt2_in        = cnt2_ff;
      wrap_in        = wrap_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      rem_in         = rem_ff;
      apply_valid_in = cmd.issue;
      apply_mask_in  = apply_mask_ff;
      apply_word_in  = apply_word_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;

      if (csr_write_enable) begin
         buf_len_in = csr_write_data;
      end
      if (cmd.clear_step) begin
         clear_addr_in = clear_addr_ff + AW'(1);
      end
      if (cmd.accept) begin
         op_in    = req_data.opcode;
         mark_in  = req_data.mark_value;
         start_in = req_data.start_slot;
         count_in = req_data.run_length;
         hit_in   = 1'b0;
      end
      if (cmd.check) begin
         quot_in = SLOT_W'(product >> SHIFT_K);
         wrap_in = (count_ff > avail);
         cnt1_in = (count_ff > avail) ? avail : count_ff;
         cnt2_in = count_ff - avail;
      end
      if (cmd.split) begin
         word_in = AW'(quot_ff);
         bit_in  = BW'(start_ff - SLOT_W'(quot_ff * SLOT_W'(WORD_BITS)));
         rem_in  = cnt1_ff;
      end
      if (cmd.issue) begin
         apply_mask_in = step_mask;
         apply_word_in = word_ff;
         word_in       = word_ff + AW'(1);
         bit_in        = '0;
         rem_in        = rem_ff - step_n;
      end
      if (cmd.load_second) begin
         word_in = '0;
         bit_in  = '0;
         rem_in  = cnt2_ff;
      end
      if (apply_valid_ff && (op_ff == OP_QUERY) && ((ram_rdata & apply_mask_ff) != '0)) begin
         hit_in = 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_in.any_marked  = (op_ff == OP_QUERY) && hit_ff && !run_error;
         rsp_in.range_error = run_error;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff     <= BUF_LEN_RESET;
         clear_addr_ff  <= '0;
         apply_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         buf_len_ff     <= buf_len_in;
         clear_addr_ff  <= clear_addr_in;
         apply_valid_ff <= apply_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      mark_ff       <= mark_in;
      start_ff      <= start_in;
      count_ff      <= count_in;
      quot_ff       <= quot_in;
      cnt1_ff       <= cnt1_in;
      cnt2_ff       <= cnt2_in;
      wrap_ff       <= wrap_in;
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      rem_ff        <= rem_in;
      apply_mask_ff <= apply_mask_in;
      apply_word_ff <= apply_word_in;
      hit_ff        <= hit_in;
      rsp_ff        <= rsp_in;
   end

   assign status.clear_last = (clear_addr_ff == LAST_WORD);
   assign status.run_error  = run_error;
   assign status.run_empty  = (count_ff == '0);
   assign status.run_wraps  = wrap_ff;
   assign status.last_step  = last_step;
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/circular_bitmap_range_mark_core.sv
`timescale 1ns / 1ps
// Channel   Ports                                  Transfer when
// request   req_valid req_stall req_data           req_valid && !req_stall
// response  rsp_valid rsp_stall rsp_data           rsp_valid && !rsp_stall
// config    csr_write_enable csr_write_data        csr_write_enable
//
// After its transfer an item passes the check and split states, one walk step per
// mark word the run touches, a drain and the finish state; a wrapping run walks its
// second piece the same way. Rejected and zero-length items skip to finish. The walk
// reads one word per cycle and writes it back in the cycle after; req_stall is low
// only while idle. After reset a clearing pass zeroes the mark RAM (1024 words at
// the default sizes), one word per cycle; a finished result holds until it transfers.

module circular_bitmap_range_mark_core #(
   parameter int MAX_SLOTS = cbrm_pkg::MAX_SLOTS_DEFAULT,
   parameter int WORD_BITS = cbrm_pkg::WORD_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  cbrm_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cbrm_pkg::rsp_type          rsp_data,
   input  logic                       csr_write_enable,
   input  logic [cbrm_pkg::LEN_W-1:0] csr_write_data
);

   import cbrm_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   cbrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cbrm_datapath #(
      .MAX_SLOTS (MAX_SLOTS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

endmodule
